// File: rtl/sfcr_pkg.sv
package sfcr_pkg;

	// Receive buffer depth in bytes; a line or frame longer than this overflows.
	localparam int BUFFER_DEPTH = 64;

	// Width of the byte counter, wide enough to hold BUFFER_DEPTH itself.
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	// Frame byte positions that feed the decoded fields.
	localparam int FB_FIRST = 2;
	localparam int FB_LAST  = 24;

	// Output word width: 150 bits of fields, padded to whole bytes.
	localparam int OUT_W = 152;

	// Special byte values.
	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;

	localparam logic [11:0] YEAR_BASE = 12'd2000;

	// Event codes.
	localparam logic [2:0] EV_OK       = 3'd0;
	localparam logic [2:0] EV_XOR      = 3'd1;
	localparam logic [2:0] EV_RESTORE  = 3'd2;
	localparam logic [2:0] EV_ECHO_OFF = 3'd3;
	localparam logic [2:0] EV_MAC      = 3'd4;
	localparam logic [2:0] EV_OTHER    = 3'd5;
	localparam logic [2:0] EV_OVERFLOW = 3'd6;

	// Command match flag bits.
	localparam int MF_RESTORE = 0;
	localparam int MF_ECHO    = 1;
	localparam int MF_MAC     = 2;

	// Command strings, first character at index zero.
	localparam logic [7:0] PAT_RESTORE [10] = '{
		8'h41, 8'h54, 8'h2B, 8'h52, 8'h45, 8'h53, 8'h54, 8'h4F, 8'h52, 8'h45
	};
	localparam logic [7:0] PAT_ECHO [4] = '{8'h41, 8'h54, 8'h45, 8'h30};
	localparam logic [7:0] PAT_MAC [12] = '{
		8'h41, 8'h54, 8'h2B, 8'h43, 8'h49, 8'h50,
		8'h53, 8'h54, 8'h41, 8'h4D, 8'h41, 8'h43
	};

	// Decoded fields of a good binary frame.
	typedef struct packed {
		logic [31:0] alert_window;
		logic [7:0]  alert_flag;
		logic [7:0]  battery_level;
		logic [7:0]  message_id_narrow;
		logic [23:0] time_of_day;
		logic [15:0] month_and_day;
		logic [11:0] year;
		logic [7:0]  reed_state;
		logic [15:0] message_id_wide;
		logic [7:0]  command;
	} frame_fields_t;

	// High nibble times ten plus low nibble, for any nibble values.
	function automatic logic [7:0] bcd_decode(input logic [7:0] v);
		logic [7:0] hi;
		hi = {4'b0, v[7:4]};
		return (hi << 3) + (hi << 1) + {4'b0, v[3:0]};
	endfunction

	// Clears the match flag of every command string that the byte at pos rules out.
	function automatic logic [2:0] match_next(
		input logic [2:0]       flags,
		input logic [CNT_W-1:0] pos,
		input logic [7:0]       c
	);
		logic [2:0] f;
		f = flags;
		if (pos >= CNT_W'(10)) begin
			f[MF_RESTORE] = 1'b0;
		end else if (PAT_RESTORE[pos[3:0]] != c) begin
			f[MF_RESTORE] = 1'b0;
		end
		if (pos >= CNT_W'(4)) begin
			f[MF_ECHO] = 1'b0;
		end else if (PAT_ECHO[pos[1:0]] != c) begin
			f[MF_ECHO] = 1'b0;
		end
		if (pos < CNT_W'(12)) begin
			if (PAT_MAC[pos[3:0]] != c) begin
				f[MF_MAC] = 1'b0;
			end
		end
		return f;
	endfunction

endpackage

// File: rtl/sfcr_fields.sv
module sfcr_fields import sfcr_pkg::*; (
	input  logic [FB_LAST:FB_FIRST][7:0] fb,      // captured frame bytes
	input  logic [CNT_W-1:0]             cnt,     // position of the byte now arriving
	input  logic [7:0]                   data_in, // byte now arriving
	output frame_fields_t                fields
);

	logic [FB_LAST:FB_FIRST][7:0] got;

	// Merge in the arriving byte; positions not yet received read as zero.
	always_comb begin
		for (int i = FB_FIRST; i <= FB_LAST; i++) begin
			if (CNT_W'(i) > cnt) begin
				got[i] = 8'h00;
			end else if (CNT_W'(i) == cnt) begin
				got[i] = data_in;
			end else begin
				got[i] = fb[i];
			end
		end
	end

	// Field decode, including the BCD date and time.
	always_comb begin
		fields.command           = got[2];
		fields.message_id_wide   = {got[9], got[10]};
		fields.reed_state        = got[11];
		fields.year              = YEAR_BASE + {4'b0, bcd_decode(got[12])};
		fields.month_and_day     = {bcd_decode(got[13]), bcd_decode(got[14])};
		fields.time_of_day       = {bcd_decode(got[15]), bcd_decode(got[16]),
			bcd_decode(got[17])};
		fields.message_id_narrow = got[18];
		fields.battery_level     = got[19];
		fields.alert_flag        = got[20];
		fields.alert_window      = {got[21], got[22], got[23], got[24]};
	end

endmodule

// File: rtl/serial_frame_and_command_receiver.sv
// Channel   Direction  Width  Contents
// s_axis    in         8      received serial byte
// m_axis    out        152    event, decoded frame fields, line length
//
// Each byte is registered on entry and then handled from the input register; the
// result for the byte that completes a line or frame is held in the output register.
// One byte is taken every cycle while the output side keeps up.
// Asynchronous reset returns the receiver to idle with the output empty.
// A stalled output holds its word and stops the input stage behind it.
module serial_frame_and_command_receiver import sfcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [2:0] event_res, [10:3] command, [26:11] message_id_wide, [34:27] reed_state,
	// [46:35] year, [62:47] month_and_day, [86:63] time_of_day,
	// [94:87] message_id_narrow, [102:95] battery_level, [110:103] alert_flag,
	// [142:111] alert_window, [149:143] line_length, [151:150] zero
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic                         valid_s1;
	logic [7:0]                   data_s1;
	logic                         out_valid_s2;
	logic [OUT_W-1:0]             out_data_s2;

	logic [CNT_W-1:0]             cnt_q;
	logic                         text_q;
	logic [7:0]                   xor_q;
	logic [7:0]                   len_q;
	logic [2:0]                   flags_q;
	logic [FB_LAST:FB_FIRST][7:0] fb_q;

	logic                         out_free;
	logic                         adv;
	logic                         idle;
	logic                         is_start;
	logic                         term;
	logic                         ovf;
	logic                         store;
	logic                         done_bin;
	logic                         res;
	logic                         frame_ok;
	logic [CNT_W-1:0]             cnt_inc;
	logic [7:0]                   len_nx;
	logic [7:0]                   xor_nx;
	logic [2:0]                   ev;
	logic [CNT_W-1:0]             line_len;
	frame_fields_t                dec_fields;
	frame_fields_t                res_fields;

	// Handshake: the input stage moves on when the output register can take a word.
	assign out_free      = !out_valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = out_data_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	sfcr_fields u_fields (
		.fb      (fb_q),
		.cnt     (cnt_q),
		.data_in (data_s1),
		.fields  (dec_fields)
	);

	// Byte classification and result selection.
	always_comb begin
		idle     = (cnt_q == '0);
		is_start = (data_s1 == SYNC_BYTE) || (data_s1 == CHAR_A);
		term     = !idle && text_q && ((data_s1 == CHAR_CR) || (data_s1 == CHAR_LF));
		ovf      = !idle && !term && (cnt_q >= CNT_W'(BUFFER_DEPTH));
		store    = !idle && !term && !ovf;
		cnt_inc  = cnt_q + CNT_W'(1);
		len_nx   = (cnt_q == CNT_W'(1)) ? data_s1 : len_q;
		xor_nx   = xor_q ^ data_s1;
		done_bin = store && !text_q && ({2'b0, cnt_inc} == ({1'b0, len_nx} + 9'd2));
		res      = term || ovf || done_bin;
		frame_ok = done_bin && (xor_nx == 8'h00);

		if (term) begin
			if (flags_q[MF_RESTORE] && (cnt_q == CNT_W'(10))) begin
				ev = EV_RESTORE;
			end else if (flags_q[MF_ECHO] && (cnt_q == CNT_W'(4))) begin
				ev = EV_ECHO_OFF;
			end else if (flags_q[MF_MAC] && (cnt_q >= CNT_W'(12))) begin
				ev = EV_MAC;
			end else begin
				ev = EV_OTHER;
			end
			line_len = cnt_q;
		end else if (ovf) begin
			ev       = EV_OVERFLOW;
			line_len = CNT_W'(BUFFER_DEPTH);
		end else begin
			ev       = frame_ok ? EV_OK : EV_XOR;
			line_len = cnt_inc;
		end

		res_fields = frame_ok ? dec_fields : '0;
	end

	// Receiver state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			text_q  <= 1'b0;
			xor_q   <= 8'h00;
			len_q   <= 8'h00;
			flags_q <= 3'b111;
		end else if (adv) begin
			if (idle) begin
				if (is_start) begin
					cnt_q   <= CNT_W'(1);
					text_q  <= (data_s1 == CHAR_A);
					xor_q   <= 8'h00;
					flags_q <= match_next(3'b111, '0, data_s1);
				end
			end else if (store) begin
				cnt_q   <= done_bin ? '0 : cnt_inc;
				xor_q   <= xor_nx;
				len_q   <= len_nx;
				flags_q <= match_next(flags_q, cnt_q, data_s1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Frame bytes at the decoded positions.
	always_ff @(posedge clk) begin
		for (int i = FB_FIRST; i <= FB_LAST; i++) begin
			if (adv && store && (cnt_q == CNT_W'(i))) begin
				fb_q[i] <= data_s1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= adv && res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res) begin
			out_data_s2 <= {2'b00, line_len, res_fields, ev};
		end
	end

	// After any result the receiver is idle again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res) |=> (cnt_q == '0))
		else $error("receiver not idle after a result");

	// A byte other than a start byte leaves an idle receiver idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && idle && !is_start) |=> (cnt_q == '0))
		else $error("idle receiver left idle on a non-start byte");

	// The text flag changes only when a new line or frame starts.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && idle) |=> $stable(text_q))
		else $error("text flag changed inside a line or frame");

	// An overflow word always carries the buffer depth as its length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && (out_data_s2[2:0] == EV_OVERFLOW))
		|-> (out_data_s2[149:143] == CNT_W'(BUFFER_DEPTH)))
		else $error("overflow word with wrong length");

endmodule

// File: bench/serial_rx_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the receiver, keeps its own copy of the receive
// state, and compares every output word with the oldest predicted event.
module serial_rx_checker import sfcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	output int               mismatches,
	output int               events_due
);

	// One output word, with the lowest field declared last.
	typedef struct packed {
		logic [1:0]    pad;
		logic [6:0]    line_length;
		frame_fields_t fields;
		logic [2:0]    event_res;
	} rx_event_t;

	rx_event_t  event_queue [$];
	int         rx_count;
	logic       rx_is_text;
	logic [7:0] rx_xor;
	logic [7:0] rx_declared;
	logic [2:0] rx_match;
	logic [7:0] rx_bytes [BUFFER_DEPTH];

	// Drops every command string that the byte at this position rules out.
	function automatic logic [2:0] narrow_matches(logic [2:0] m, int pos, logic [7:0] c);
		if (pos >= 10) begin
			m[MF_RESTORE] = 1'b0;
		end else if (PAT_RESTORE[pos] != c) begin
			m[MF_RESTORE] = 1'b0;
		end
		if (pos >= 4) begin
			m[MF_ECHO] = 1'b0;
		end else if (PAT_ECHO[pos] != c) begin
			m[MF_ECHO] = 1'b0;
		end
		if (pos < 12) begin
			if (PAT_MAC[pos] != c) begin
				m[MF_MAC] = 1'b0;
			end
		end
		return m;
	endfunction

	// Bytes past the end of the current frame read as zero.
	function automatic logic [7:0] held(int i);
		return (i < rx_count) ? rx_bytes[i] : 8'h00;
	endfunction

	function automatic logic [7:0] bcd_value(logic [7:0] v);
		return 8'(v[7:4] * 10 + v[3:0]);
	endfunction

	task automatic queue_event(logic [2:0] ev, int len, frame_fields_t f);
		rx_event_t e;
		e = '0;
		e.event_res = ev;
		e.fields = f;
		e.line_length = 7'(len);
		event_queue.push_back(e);
		rx_count = 0;
	endtask

	// Advances the receive state by one accepted word.
	task automatic advance_receiver(logic [7:0] d);
		frame_fields_t f;
		logic [2:0]    ev;
		f = '0;
		if (rx_count == 0) begin
			// Idle: only a sync byte or an 'A' opens something.
			if (d == SYNC_BYTE || d == CHAR_A) begin
				rx_bytes[0] = d;
				rx_count = 1;
				rx_is_text = (d == CHAR_A);
				rx_xor = '0;
				rx_match = narrow_matches(3'b111, 0, d);
			end
		end else if (rx_is_text && (d == CHAR_CR || d == CHAR_LF)) begin
			if (rx_match[MF_RESTORE] && rx_count == 10) begin
				ev = EV_RESTORE;
			end else if (rx_match[MF_ECHO] && rx_count == 4) begin
				ev = EV_ECHO_OFF;
			end else if (rx_match[MF_MAC] && rx_count >= 12) begin
				ev = EV_MAC;
			end else begin
				ev = EV_OTHER;
			end
			queue_event(ev, rx_count, f);
		end else if (rx_count >= BUFFER_DEPTH) begin
			queue_event(EV_OVERFLOW, BUFFER_DEPTH, f);
		end else begin
			rx_bytes[rx_count] = d;
			if (rx_count == 1) begin
				rx_declared = d;
			end
			rx_match = narrow_matches(rx_match, rx_count, d);
			rx_count++;
			rx_xor ^= d;
			// A binary frame ends after its declared length plus the two header bytes.
			if (!rx_is_text && rx_count == int'(rx_declared) + 2) begin
				if (rx_xor != 8'h00) begin
					queue_event(EV_XOR, rx_count, f);
				end else begin
					f.command = held(2);
					f.message_id_wide = {held(9), held(10)};
					f.reed_state = held(11);
					f.year = 12'(bcd_value(held(12))) + YEAR_BASE;
					f.month_and_day = {bcd_value(held(13)), bcd_value(held(14))};
					f.time_of_day = {bcd_value(held(15)), bcd_value(held(16)),
						bcd_value(held(17))};
					f.message_id_narrow = held(18);
					f.battery_level = held(19);
					f.alert_flag = held(20);
					f.alert_window = {held(21), held(22), held(23), held(24)};
					queue_event(EV_OK, rx_count, f);
				end
			end
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			mismatches++;
		end
	endtask

	// Output words are compared before the input word of the same edge is
	// predicted, so a word can never be matched against its own cause.
	always @(posedge clk or negedge arst_n) begin
		rx_event_t seen;
		rx_event_t want;
		if (!arst_n) begin
			rx_count = 0;
			rx_is_text = 1'b0;
			rx_xor = '0;
			rx_declared = '0;
			rx_match = 3'b111;
			rx_bytes = '{default: 8'h00};
			event_queue.delete();
			mismatches = 0;
			events_due = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen = rx_event_t'(m_axis_tdata);
				if (event_queue.size() == 0) begin
					$error("unexpected output word 0x%0h", m_axis_tdata);
					mismatches++;
				end else begin
					want = event_queue.pop_front();
					check_field("event_res", want.event_res, seen.event_res);
					check_field("command", want.fields.command, seen.fields.command);
					check_field("message_id_wide", want.fields.message_id_wide,
						seen.fields.message_id_wide);
					check_field("reed_state", want.fields.reed_state, seen.fields.reed_state);
					check_field("year", want.fields.year, seen.fields.year);
					check_field("month_and_day", want.fields.month_and_day,
						seen.fields.month_and_day);
					check_field("time_of_day", want.fields.time_of_day,
						seen.fields.time_of_day);
					check_field("message_id_narrow", want.fields.message_id_narrow,
						seen.fields.message_id_narrow);
					check_field("battery_level", want.fields.battery_level,
						seen.fields.battery_level);
					check_field("alert_flag", want.fields.alert_flag, seen.fields.alert_flag);
					check_field("alert_window", want.fields.alert_window,
						seen.fields.alert_window);
					check_field("line_length", want.line_length, seen.line_length);
					check_field("pad", want.pad, seen.pad);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_receiver(s_axis_tdata);
			end
			events_due = event_queue.size();
		end
	end

endmodule

// File: bench/serial_frame_and_command_receiver_tb.sv
`timescale 1ns / 1ps

// Drives serial words into the receiver in phases of differing back-pressure
// and reports the checker's verdict.
module serial_frame_and_command_receiver_tb import sfcr_pkg::*;;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = 8'h00;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	int               mismatches;
	int               events_due;
	int               sender_idle_pct = 0;
	int               receiver_stall_pct = 0;
	int               hold_requests = 0;
	int               bytes_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	serial_frame_and_command_receiver u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	serial_rx_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.events_due    (events_due)
	);

	// Output side: random stalls, or one long hold-off when asked for.
	initial begin
		int holds_done;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Offers one word, with random idle cycles ahead of it. Valid stays high
	// after the handshake so back-to-back words need no second assignment.
	task automatic put_byte(logic [7:0] b, bit ignored = 1'b0);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (!ignored) begin
			bytes_sent++;
		end
	endtask

	// Payload bytes lean toward the extremes, BCD corner values and terminators.
	function automatic logic [7:0] payload_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return CHAR_CR;
			3: return CHAR_LF;
			4: return 8'h99;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF);
		return b;
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == SYNC_BYTE || b == CHAR_A);
		return b;
	endfunction

	function automatic string near_miss();
		case ($urandom_range(6))
			0: return "ATE";
			1: return "ATE0X";
			2: return "AT+RESTOR";
			3: return "AT+RESTOREX";
			4: return "AT+CIPSTAMA";
			5: return "ATE1";
			default: return "AT+RESTORF";
		endcase
	endfunction

	// Binary frame with a matching or a broken XOR. Frames too long for the
	// buffer stop at the first word that overflows it.
	task automatic send_frame(int len, bit corrupt);
		logic [7:0] body [$];
		logic [7:0] sum;
		sum = 8'(len);
		for (int i = 0; i < len; i++) begin
			body.push_back(payload_byte());
		end
		if (len > 0) begin
			for (int i = 0; i < len - 1; i++) begin
				sum ^= body[i];
			end
			body[len - 1] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
		end
		put_byte(SYNC_BYTE);
		put_byte(8'(len));
		foreach (body[i]) begin
			if (i + 2 <= BUFFER_DEPTH) begin
				put_byte(body[i]);
			end
		end
	endtask

	// Text line: a fixed head, random tail, then CR, LF or both.
	task automatic send_text(string head, int tail_len);
		for (int i = 0; i < head.len(); i++) begin
			put_byte(head[i]);
		end
		for (int i = 0; i < tail_len; i++) begin
			put_byte(text_byte());
		end
		case ($urandom_range(2))
			0: put_byte(CHAR_CR);
			1: put_byte(CHAR_LF);
			default: begin
				put_byte(CHAR_CR);
				put_byte(CHAR_LF, 1'b1);
			end
		endcase
	endtask

	task automatic send_random_sequence();
		case ($urandom_range(19))
			0, 1, 2, 3, 4: send_frame($urandom_range(0, 26), 1'b0);
			5, 6: send_frame($urandom_range(23, 62), 1'b0);
			7: send_frame($urandom_range(1, 30), 1'b1);
			8: send_frame($urandom_range(63, 255), 1'b0);
			9: send_text("AT+RESTORE", 0);
			10: send_text("ATE0", 0);
			11: send_text("AT+CIPSTAMAC", $urandom_range(0, 12));
			12, 13: send_text(near_miss(), 0);
			14, 15: send_text("A", $urandom_range(0, 20));
			16: send_text("A", $urandom_range(62, 64));
			17: put_byte(noise_byte(), 1'b1);
			default: put_byte(8'($urandom));
		endcase
	endtask

	// Stops offering words until every predicted event has come out or DRAIN_LIMIT runs out.
	task automatic wait_for_events();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		do begin
			@(negedge clk);
			waited++;
		end while (events_due != 0 && waited < DRAIN_LIMIT);
		@(posedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int goal);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		goal += bytes_sent;
		while (bytes_sent < goal) begin
			send_random_sequence();
		end
		wait_for_events();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: dropped idle bytes, an empty frame and the two exact commands.
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b1);
		send_frame(0, 1'b0);
		send_text("ATE0", 0);
		send_text("AT+RESTORE", 0);
		wait_for_events();

		run_phase(0, 0, 180);

		// Long output hold-off while short lines keep coming, so the input stalls.
		hold_requests++;
		repeat (12) send_text("AT", 0);
		wait_for_events();

		run_phase(0, 0, 100);
		run_phase(72, 0, 260);
		run_phase(0, 72, 260);
		run_phase(23, 23, 260);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (events_due != 0) begin
			$error("%0d predicted events never came out", events_due);
		end
		if (mismatches == 0 && events_due == 0) begin
			$display("serial_frame_and_command_receiver_tb: done, clean");
		end else begin
			$display("serial_frame_and_command_receiver_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("serial_frame_and_command_receiver_tb: done, errors");
		$finish;
	end

endmodule
